### hw/rtl/bcds_pkg.sv
`default_nettype none
package bcds_pkg;

	localparam logic [7:0] CALL_HALT = 8'h02;
	localparam logic [7:0] CALL_DIV  = 8'h06;
	localparam logic [7:0] CALL_SQRT = 8'h08;

	localparam logic [1:0] WSET_NONE = 2'd0;
	localparam logic [1:0] WSET_ROOT = 2'd1;
	localparam logic [1:0] WSET_REGS = 2'd2;

	localparam int DIV_STEPS = 32;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HALT,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        neg_q;
		logic        neg_r;
		logic [31:0] divisor;
		logic [31:0] num;
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] rad;
		logic [17:0] srem;
		logic [15:0] root;
	} work_t;

	typedef struct packed {
		logic        handled;
		logic        halt_request;
		logic [1:0]  write_set;
		logic [31:0] value_first;
		logic [31:0] value_second;
		logic [31:0] value_third;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/bcds_call_if.sv
`default_nettype none
interface bcds_call_if;
	logic        valid;
	logic        ready;
	logic [7:0]  call_number;
	logic [31:0] arg_first;
	logic [31:0] arg_second;

	modport source (output valid, output call_number, output arg_first, output arg_second,
		input ready);
	modport sink (input valid, input call_number, input arg_first, input arg_second,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/bcds_result_if.sv
`default_nettype none
interface bcds_result_if;
	logic        valid;
	logic        ready;
	logic        handled;
	logic        halt_request;
	logic [1:0]  write_set;
	logic [31:0] value_first;
	logic [31:0] value_second;
	logic [31:0] value_third;

	modport source (output valid, output handled, output halt_request, output write_set,
		output value_first, output value_second, output value_third, input ready);
	modport sink (input valid, input handled, input halt_request, input write_set,
		input value_first, input value_second, input value_third, output ready);
endinterface
`default_nettype wire

### hw/rtl/bcds_prep.sv
`default_nettype none
module bcds_prep
	import bcds_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        vld_in,
	input  wire logic [7:0]  call_number,
	input  wire logic [31:0] arg_first,
	input  wire logic [31:0] arg_second,
	output logic             vld_s1,
	output work_t            work_s1
);

	work_t nxt;

	always_comb begin
		logic neg_a;
		logic neg_b;
		neg_a = arg_first[31];
		neg_b = arg_second[31];
		nxt = '0;
		nxt.op = OP_NONE;
		if (call_number == CALL_HALT) begin
			nxt.op = OP_HALT;
		end else if (call_number == CALL_DIV) begin
			if ((arg_first != 32'd0) && (arg_second != 32'd0)) begin
				nxt.op = OP_DIV;
			end
		end else if (call_number == CALL_SQRT) begin
			nxt.op = OP_SQRT;
		end
		nxt.neg_q   = neg_a ^ neg_b;
		nxt.neg_r   = neg_a;
		nxt.num     = neg_a ? (32'd0 - arg_first) : arg_first;
		nxt.divisor = neg_b ? (32'd0 - arg_second) : arg_second;
		nxt.rad     = arg_first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bcds_step.sv
`default_nettype none
module bcds_step
	import bcds_pkg::*;
#(
	parameter bit SQRT_STEP = 1'b0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  vld_in,
	input  wire work_t work_in,
	output logic       vld_s,
	output work_t      work_s
);

	work_t nxt;

	always_comb begin
		logic [32:0] part;
		logic [33:0] ddiff;
		logic [19:0] spart;
		logic [17:0] trial;
		logic [20:0] sdiff;
		nxt = work_in;

		// one bit of restoring division
		part  = {work_in.rem, work_in.num[31]};
		ddiff = {1'b0, part} - {2'b00, work_in.divisor};
		nxt.num = {work_in.num[30:0], 1'b0};
		nxt.quo = {work_in.quo[30:0], ~ddiff[33]};
		nxt.rem = ddiff[33] ? part[31:0] : ddiff[31:0];

		// one digit of the square root on alternate stages
		spart = {work_in.srem, work_in.rad[31:30]};
		trial = {work_in.root, 2'b01};
		sdiff = {1'b0, spart} - {3'b000, trial};
		if (SQRT_STEP) begin
			nxt.rad  = {work_in.rad[29:0], 2'b00};
			nxt.root = {work_in.root[14:0], ~sdiff[20]};
			nxt.srem = sdiff[20] ? spart[17:0] : sdiff[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (adv) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s <= nxt;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bcds_post.sv
`default_nettype none
module bcds_post
	import bcds_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  vld_in,
	input  wire work_t work_in,
	output logic       vld_q,
	output result_t    rsp_q
);

	result_t nxt;

	always_comb begin
		nxt = '0;
		unique case (work_in.op)
			OP_NONE: begin
				nxt = '0;
			end
			OP_HALT: begin
				nxt.handled      = 1'b1;
				nxt.halt_request = 1'b1;
			end
			OP_DIV: begin
				nxt.handled      = 1'b1;
				nxt.write_set    = WSET_REGS;
				nxt.value_first  = work_in.neg_q ? (32'd0 - work_in.quo) : work_in.quo;
				nxt.value_second = work_in.neg_r ? (32'd0 - work_in.rem) : work_in.rem;
				nxt.value_third  = work_in.quo;
			end
			OP_SQRT: begin
				nxt.handled     = 1'b1;
				nxt.write_set   = WSET_ROOT;
				nxt.value_first = {16'd0, work_in.root};
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= nxt;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bios_call_divide_sqrt_unit.sv
// Pipeline: an accepted request passes the decode register, 32 step stages and the output register.
// Throughput: one request per cycle while the output is not stalled; each step stage does one
// quotient bit, odd stages also one root digit. A stalled output freezes the whole pipeline.
// Reset clears every stage valid bit asynchronously; payload registers are not reset.
`default_nettype none
module bios_call_divide_sqrt_unit
	import bcds_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	bcds_call_if.sink     call,
	bcds_result_if.source result
);

	logic                 adv;
	logic [DIV_STEPS:0]   vld_s;
	work_t                work_s [DIV_STEPS+1];
	logic                 out_vld;
	result_t              out_rsp;

	assign adv        = !out_vld || result.ready;
	assign call.ready = adv;

	bcds_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.vld_in      (call.valid),
		.call_number (call.call_number),
		.arg_first   (call.arg_first),
		.arg_second  (call.arg_second),
		.vld_s1      (vld_s[0]),
		.work_s1     (work_s[0])
	);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		bcds_step #(
			.SQRT_STEP ((k % 2) == 1)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (vld_s[k]),
			.work_in (work_s[k]),
			.vld_s   (vld_s[k+1]),
			.work_s  (work_s[k+1])
		);
	end

	bcds_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (vld_s[DIV_STEPS]),
		.work_in (work_s[DIV_STEPS]),
		.vld_q   (out_vld),
		.rsp_q   (out_rsp)
	);

	assign result.valid        = out_vld;
	assign result.handled      = out_rsp.handled;
	assign result.halt_request = out_rsp.halt_request;
	assign result.write_set    = out_rsp.write_set;
	assign result.value_first  = out_rsp.value_first;
	assign result.value_second = out_rsp.value_second;
	assign result.value_third  = out_rsp.value_third;

	a_regs_handled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && (out_rsp.write_set != WSET_NONE)) |-> out_rsp.handled)
		else $error("register write on unhandled call");

	a_unhandled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && !out_rsp.handled) |-> ((out_rsp.write_set == WSET_NONE) &&
		!out_rsp.halt_request && (out_rsp.value_first == 32'd0) &&
		(out_rsp.value_second == 32'd0) && (out_rsp.value_third == 32'd0)))
		else $error("unhandled call carries data");

	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && out_rsp.halt_request) |-> (out_rsp.write_set == WSET_NONE))
		else $error("halt request with register write");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && (out_rsp.write_set == WSET_ROOT)) |-> (out_rsp.value_first[31:16] == 16'd0))
		else $error("square root exceeds 16 bits");

endmodule
`default_nettype wire
